@@ design/dcrle_pkg.sv @@
// Shared types and constants for the DCT coefficient run-length encoder.
`timescale 1ns / 1ps

package dcrle_pkg;

	localparam int COEF_W       = 16;
	localparam int RUN_W        = 6;
	localparam int VALUE_W      = 17;
	localparam int COUNT_W      = 7;
	localparam int DEF_BLOCK_SIZE = 64;
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_DC  = 2'd0,
		KIND_AC  = 2'd1,
		KIND_EOB = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                      kind;
		logic [RUN_W-1:0]           zero_run;
		logic signed [VALUE_W-1:0]  value;
		logic [COUNT_W-1:0]         count;
		logic                       last;
	} symbol_t;

	// Up to two symbols produced by one coefficient, packed from slot 0.
	typedef struct packed {
		logic [1:0] num;
		symbol_t    sym0;
		symbol_t    sym1;
	} push_t;

endpackage

@@ design/dct_coefficient_run_length_encoder.sv @@
// Top level of the zig-zag DCT coefficient run-length encoder.
// Accepts one quantized coefficient per transaction, BLOCK_SIZE transactions
// per block, and emits DC, AC (zero run, value) and end-of-block symbols.
// The block's first coefficient gives a DC symbol: raw after reset or when
// new_frame is set on that coefficient, else the difference from the previous
// block's DC. Each nonzero later coefficient gives an AC symbol with the count
// of zeros before it (no cap at 15, no ZRL). Trailing zeros give nothing; the
// last coefficient is followed by an EOB symbol whose count is AC pairs + 1.
// Timing: a coefficient is registered on input and then turned into symbols
// from that register, which lands them in a four-entry output queue. One
// coefficient is taken per cycle as long as the queue holds at most two
// symbols, so the sustained rate is one coefficient per cycle, bounded by the
// output side taking one symbol per cycle (a block yields up to BLOCK_SIZE+1
// symbols). new_frame is ignored except on a block's first coefficient.
`timescale 1ns / 1ps

module dct_coefficient_run_length_encoder
	import dcrle_pkg::*;
#(
	parameter int BLOCK_SIZE = DEF_BLOCK_SIZE
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// coefficient channel
	input  logic                      coef_valid,
	output logic                      coef_stall,
	input  logic signed [COEF_W-1:0]  coefficient,
	input  logic                      new_frame,
	// symbol channel
	output logic                      sym_valid,
	input  logic                      sym_stall,
	output logic [1:0]                symbol_kind,
	output logic [RUN_W-1:0]          zero_run,
	output logic signed [VALUE_W-1:0] symbol_value,
	output logic [COUNT_W-1:0]        symbol_count,
	output logic                      last
);

	logic                     valid_s1;
	logic signed [COEF_W-1:0] coefficient_s1;
	logic                     new_frame_s1;

	logic                  room;
	logic                  advance;
	logic                  pop;
	logic [FIFO_CNT_W-1:0] fill;
	push_t                 push;
	symbol_t               head;

	// Stage 1 may retire only if the queue can absorb two symbols.
	assign room       = (fill <= FIFO_CNT_W'(FIFO_DEPTH - 2));
	assign advance    = valid_s1 && room;
	assign coef_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!coef_stall) begin
			valid_s1 <= coef_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (coef_valid && !coef_stall) begin
			coefficient_s1 <= coefficient;
			new_frame_s1   <= new_frame;
		end
	end

	dcrle_encode #(
		.BLOCK_SIZE(BLOCK_SIZE)
	) u_encode (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.coefficient(coefficient_s1),
		.new_frame  (new_frame_s1),
		.push       (push)
	);

	assign pop = sym_valid && !sym_stall;

	dcrle_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.not_empty(sym_valid),
		.fill     (fill),
		.head     (head)
	);

	assign symbol_kind  = head.kind;
	assign zero_run     = head.zero_run;
	assign symbol_value = head.value;
	assign symbol_count = head.count;
	assign last         = head.last;

endmodule

@@ design/dcrle_encode.sv @@
// Per-coefficient symbol generation and block/DC prediction state.
`timescale 1ns / 1ps

module dcrle_encode
	import dcrle_pkg::*;
#(
	parameter int BLOCK_SIZE = DEF_BLOCK_SIZE
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  logic signed [COEF_W-1:0] coefficient,
	input  logic                     new_frame,
	output push_t                    push
);

	localparam int POS_W = $clog2(BLOCK_SIZE);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_SIZE - 1);

	logic signed [COEF_W-1:0] dc_previous_q;
	logic                     first_block_q;
	logic [POS_W-1:0]         position_q;
	logic [RUN_W-1:0]         zero_count_q;
	logic [RUN_W-1:0]         pair_count_q;

	logic                      at_start;
	logic                      at_end;
	logic                      is_zero;
	logic                      emit_ac;
	logic signed [VALUE_W-1:0] coef_ext;
	logic signed [VALUE_W-1:0] dc_value;
	logic [RUN_W-1:0]          pair_next;
	symbol_t                   sym_main;
	symbol_t                   sym_eob;

	assign at_start = (position_q == '0);
	assign at_end   = (position_q == LAST_POS);
	assign is_zero  = (coefficient == '0);
	assign emit_ac  = !at_start && !is_zero;
	assign coef_ext = VALUE_W'(coefficient);
	assign dc_value = (new_frame || first_block_q) ? coef_ext
		: coef_ext - VALUE_W'(dc_previous_q);
	assign pair_next = emit_ac ? pair_count_q + RUN_W'(1) : pair_count_q;

	always_comb begin
		sym_main.kind     = at_start ? KIND_DC : KIND_AC;
		sym_main.zero_run = at_start ? '0 : zero_count_q;
		sym_main.value    = at_start ? dc_value : coef_ext;
		sym_main.count    = '0;
		sym_main.last     = 1'b0;

		sym_eob.kind      = KIND_EOB;
		sym_eob.zero_run  = '0;
		sym_eob.value     = '0;
		sym_eob.count     = COUNT_W'(pair_next) + COUNT_W'(1);
		sym_eob.last      = 1'b1;

		push.sym1 = sym_eob;
		if (at_start || emit_ac) begin
			push.sym0 = sym_main;
			push.num  = at_end ? 2'd2 : 2'd1;
		end else begin
			push.sym0 = sym_eob;
			push.num  = at_end ? 2'd1 : 2'd0;
		end
		if (!advance) begin
			push.num = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_previous_q <= '0;
			first_block_q <= 1'b1;
			position_q    <= '0;
			zero_count_q  <= '0;
			pair_count_q  <= '0;
		end else if (advance) begin
			if (at_start) begin
				dc_previous_q <= coefficient;
				first_block_q <= 1'b0;
			end
			if (at_end) begin
				position_q   <= '0;
				zero_count_q <= '0;
				pair_count_q <= '0;
			end else begin
				position_q <= position_q + POS_W'(1);
				if (at_start) begin
					zero_count_q <= '0;
					pair_count_q <= '0;
				end else if (is_zero) begin
					zero_count_q <= zero_count_q + RUN_W'(1);
				end else begin
					zero_count_q <= '0;
					pair_count_q <= pair_next;
				end
			end
		end
	end

endmodule

@@ design/dcrle_fifo.sv @@
// Small symbol queue: up to two writes and one read per cycle.
`timescale 1ns / 1ps

module dcrle_fifo
	import dcrle_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  push_t                 push,
	input  logic                  pop,
	output logic                  not_empty,
	output logic [FIFO_CNT_W-1:0] fill,
	output symbol_t               head
);

	symbol_t                entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [FIFO_CNT_W-1:0]  fill_q;
	logic [FIFO_PTR_W-1:0]  wr_ptr_b;

	assign wr_ptr_b  = wr_ptr_q + FIFO_PTR_W'(1);
	assign not_empty = (fill_q != '0);
	assign fill      = fill_q;
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			entry_q[wr_ptr_q] <= push.sym0;
		end
		if (push.num == 2'd2) begin
			entry_q[wr_ptr_b] <= push.sym1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.num);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			fill_q <= fill_q + FIFO_CNT_W'(push.num) - FIFO_CNT_W'(pop);
		end
	end

endmodule

@@ dv/dct_coefficient_run_length_encoder_test.sv @@
// Self-checking testbench for the DCT coefficient run-length encoder.
`timescale 1ns / 1ps

module dct_coefficient_run_length_encoder_test;
	import dcrle_pkg::*;

	localparam int BLOCK_LEN = DEF_BLOCK_SIZE;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;

	typedef logic signed [COEF_W-1:0] coef_block_t [BLOCK_LEN];

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      coef_valid;
	logic                      coef_stall;
	logic signed [COEF_W-1:0]  coefficient;
	logic                      new_frame;
	logic                      sym_valid;
	logic                      sym_stall;
	logic [1:0]                symbol_kind;
	logic [RUN_W-1:0]          zero_run;
	logic signed [VALUE_W-1:0] symbol_value;
	logic [COUNT_W-1:0]        symbol_count;
	logic                      last;

	// Expected symbols, oldest first.
	symbol_t pending_symbols[$];
	int      error_count = 0;

	// steady: neither side idles. hold_active: receiver holds off regardless.
	bit steady = 1'b0;
	bit hold_active = 1'b0;

	// Encoder state mirrored by the predictor.
	logic signed [COEF_W-1:0] dc_prev = '0;
	bit                       dc_raw_next = 1'b1;
	int                       blk_pos = 0;
	int                       zeros_seen = 0;
	int                       pairs_seen = 0;

	dct_coefficient_run_length_encoder #(
		.BLOCK_SIZE(BLOCK_LEN)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.coef_valid  (coef_valid),
		.coef_stall  (coef_stall),
		.coefficient (coefficient),
		.new_frame   (new_frame),
		.sym_valid   (sym_valid),
		.sym_stall   (sym_stall),
		.symbol_kind (symbol_kind),
		.zero_run    (zero_run),
		.symbol_value(symbol_value),
		.symbol_count(symbol_count),
		.last        (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Work out the symbols one accepted coefficient produces and queue them.
	task automatic encode_coefficient(input logic signed [COEF_W-1:0] coef, input logic restart);
		symbol_t                   sym;
		logic signed [VALUE_W-1:0] diff;
		if (blk_pos == 0) begin
			// DC: raw after reset or a frame restart, else delta vs last block's DC
			if (restart)
				dc_raw_next = 1'b1;
			diff = dc_raw_next ? VALUE_W'(coef) : VALUE_W'(coef) - VALUE_W'(dc_prev);
			dc_raw_next = 1'b0;
			dc_prev = coef;
			zeros_seen = 0;
			pairs_seen = 0;
			sym.kind = KIND_DC;
			sym.zero_run = '0;
			sym.value = diff;
			sym.count = '0;
			sym.last = 1'b0;
			pending_symbols.push_back(sym);
		end else if (coef == 0) begin
			zeros_seen = (zeros_seen + 1) % 64;
		end else begin
			// nonzero AC: run of zeros since the previous nonzero, no ZRL split
			sym.kind = KIND_AC;
			sym.zero_run = RUN_W'(zeros_seen);
			sym.value = VALUE_W'(coef);
			sym.count = '0;
			sym.last = 1'b0;
			pending_symbols.push_back(sym);
			pairs_seen = (pairs_seen + 1) % 64;
			zeros_seen = 0;
		end
		if (blk_pos >= BLOCK_LEN - 1) begin
			// EOB closes every block, trailing zeros are dropped
			sym.kind = KIND_EOB;
			sym.zero_run = '0;
			sym.value = '0;
			sym.count = COUNT_W'(pairs_seen + 1);
			sym.last = 1'b1;
			pending_symbols.push_back(sym);
			blk_pos = 0;
			zeros_seen = 0;
			pairs_seen = 0;
		end else begin
			blk_pos = blk_pos + 1;
		end
	endtask

	// Offer one coefficient, with an occasional idle gap in front, and wait for
	// the transaction. Valid stays high afterwards; the next call decides.
	task automatic send_coefficient(input logic signed [COEF_W-1:0] coef, input logic restart);
		if (!steady && $urandom_range(99) < 6) begin
			@(negedge clk);
			coef_valid <= 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		coef_valid <= 1'b1;
		coefficient <= coef;
		new_frame <= restart;
		do
			@(posedge clk);
		while (coef_stall);
		encode_coefficient(coef, restart);
	endtask

	task automatic send_block(input coef_block_t coefs, input logic [BLOCK_LEN-1:0] restarts);
		for (int i = 0; i < BLOCK_LEN; i++)
			send_coefficient(coefs[i], restarts[i]);
	endtask

	// Random coefficient: mostly small magnitudes, sometimes the full 16 bits.
	function automatic logic signed [COEF_W-1:0] random_coefficient();
		case ($urandom_range(3))
			0: return COEF_W'($urandom);
			1: return COEF_W'(int'($urandom_range(16)) - 8);
			default: return COEF_W'(int'($urandom_range(510)) - 255);
		endcase
	endfunction

	// One block with a given percentage of nonzero AC positions. new_frame is
	// set now and then on the first item and, to be ignored, on later items.
	task automatic send_random_block(input int density);
		coef_block_t           coefs;
		logic [BLOCK_LEN-1:0]  restarts;
		coefs[0] = random_coefficient();
		restarts[0] = ($urandom_range(7) == 0);
		for (int i = 1; i < BLOCK_LEN; i++) begin
			coefs[i] = (int'($urandom_range(99)) < density) ? random_coefficient() : '0;
			restarts[i] = ($urandom_range(19) == 0);
		end
		send_block(coefs, restarts);
	endtask

	// Drop valid and let every outstanding symbol come out.
	task automatic wait_for_drain();
		@(negedge clk);
		coef_valid <= 1'b0;
		while (pending_symbols.size() != 0)
			@(posedge clk);
	endtask

	// DC prediction: raw values on restarts, extreme deltas in both directions,
	// new_frame off the block start has no effect.
	task automatic test_dc_prediction();
		coef_block_t          coefs;
		logic [BLOCK_LEN-1:0] restarts;
		coefs = '{default: '0};
		restarts = '0;
		restarts[0] = 1'b1;
		coefs[0] = -16'sd32768;
		send_block(coefs, restarts);
		restarts = '0;
		coefs[0] = 16'sd32767;          // delta +65535
		send_block(coefs, restarts);
		coefs[0] = -16'sd32768;         // delta -65535
		restarts[5] = 1'b1;             // ignored, not on the first item
		send_block(coefs, restarts);
		restarts = '0;
		restarts[0] = 1'b1;
		coefs[0] = 16'sd5;              // raw again
		send_block(coefs, restarts);
	endtask

	// AC extremes: full-scale values, a nonzero last coefficient giving a pair
	// and EOB together, every position nonzero (largest count), longest run.
	task automatic test_ac_extremes();
		coef_block_t          coefs;
		logic [BLOCK_LEN-1:0] restarts;
		restarts = '0;
		coefs = '{default: '0};
		coefs[0] = 16'sd100;
		coefs[1] = 16'sd32767;
		coefs[2] = -16'sd32768;
		coefs[BLOCK_LEN-1] = 16'sd1;
		send_block(coefs, restarts);
		for (int i = 0; i < BLOCK_LEN; i++)
			coefs[i] = (i % 2 == 0) ? -16'sd1 : COEF_W'(i * 517);
		send_block(coefs, restarts);
		coefs = '{default: '0};
		coefs[BLOCK_LEN-1] = -16'sd2;   // run spans the whole AC range
		send_block(coefs, restarts);
	endtask

	task automatic test_random_blocks();
		for (int b = 0; b < 2; b++)
			send_random_block($urandom_range(100));
	endtask

	// Receiver holds off long enough that the output queue fills and the input
	// stalls, while dense blocks keep coming; then the sender waits for drain.
	task automatic test_backpressure();
		fork
			begin
				@(posedge clk);
				hold_active = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
			end
			begin
				send_random_block(90);
				send_random_block(100);
			end
		join
		wait_for_drain();
	endtask

	// Back-to-back traffic with no idling on either side.
	task automatic test_steady_stream();
		steady = 1'b1;
		for (int b = 0; b < 3; b++)
			send_random_block(b * 50);
		steady = 1'b0;
	endtask

	// Receiver stall: random, or held by the back-pressure test.
	always @(negedge clk)
		sym_stall <= hold_active || (!steady && $urandom_range(99) < 6);

	// Compare each symbol transaction with the oldest expectation.
	always @(posedge clk) begin
		symbol_t want;
		if (arst_n && sym_valid && !sym_stall) begin
			if (pending_symbols.size() == 0) begin
				$display("%0t: unexpected symbol kind %0d value %0d", $time,
					symbol_kind, symbol_value);
				error_count++;
			end else begin
				want = pending_symbols.pop_front();
				if (symbol_kind !== want.kind) begin
					$display("%0t: symbol_kind expected %0d actual %0d", $time,
						want.kind, symbol_kind);
					error_count++;
				end
				if (zero_run !== want.zero_run) begin
					$display("%0t: zero_run expected %0d actual %0d", $time,
						want.zero_run, zero_run);
					error_count++;
				end
				if (symbol_value !== want.value) begin
					$display("%0t: symbol_value expected %0d actual %0d", $time,
						want.value, symbol_value);
					error_count++;
				end
				if (symbol_count !== want.count) begin
					$display("%0t: symbol_count expected %0d actual %0d", $time,
						want.count, symbol_count);
					error_count++;
				end
				if (last !== want.last) begin
					$display("%0t: last expected %0d actual %0d", $time,
						want.last, last);
					error_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		coef_valid = 1'b0;
		coefficient = '0;
		new_frame = 1'b0;
		sym_stall = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_dc_prediction();
		test_ac_extremes();
		test_random_blocks();
		test_backpressure();
		test_steady_stream();
		test_random_blocks();

		wait_for_drain();
		// catch anything extra the block might still emit
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("dct_coefficient_run_length_encoder_test passed");
		else
			$display("dct_coefficient_run_length_encoder_test failed");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("dct_coefficient_run_length_encoder_test failed");
		$finish;
	end

endmodule

@@ files.f @@
design/dcrle_pkg.sv
design/dcrle_encode.sv
design/dcrle_fifo.sv
design/dct_coefficient_run_length_encoder.sv
dv/dct_coefficient_run_length_encoder_test.sv
